[design/mlf_pkg.sv]
//------------------------------------------------------------------------------
// mlf_pkg
// Shared widths, constants and controller/datapath handshake types for the
// MAC learning forwarder.
//------------------------------------------------------------------------------
`default_nettype none

package mlf_pkg;

	localparam int MAC_W            = 48;
	localparam int PORT_W           = 4;
	localparam int CFG_W            = 4;
	localparam int NUM_PORTS_DEF    = 10;
	localparam int TABLE_DEPTH_DEF  = 64;

	localparam logic [MAC_W-1:0] BCAST_MAC        = {MAC_W{1'b1}};
	localparam logic [CFG_W-1:0] ACTIVE_PORTS_RST = CFG_W'(10);

	// controller -> datapath
	typedef struct packed {
		logic load;    // take the header item, restart the scan
		logic rd_en;   // read the next table entry
		logic commit;  // learn (if due) and load the result register
	} mlf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic tbl_empty; // no entries stored
		logic rd_last;   // current read address is the last filled entry
		logic out_free;  // result register can take a new item this cycle
	} mlf_sts_t;

endpackage

`default_nettype wire

[design/mlf_if.sv]
//------------------------------------------------------------------------------
// mlf_if
// Valid/ready channels of the MAC learning forwarder: header in, result out,
// and the active-port configuration write.
//------------------------------------------------------------------------------
`default_nettype none

interface mlf_hdr_if;
	logic                           valid;
	logic                           ready;
	logic [mlf_pkg::MAC_W-1:0]      src_mac;
	logic [mlf_pkg::MAC_W-1:0]      dst_mac;
	logic [mlf_pkg::PORT_W-1:0]     in_port;

	modport source (output valid, src_mac, dst_mac, in_port, input ready);
	modport sink   (input valid, src_mac, dst_mac, in_port, output ready);
endinterface

interface mlf_fwd_if #(
	parameter int NUM_PORTS = mlf_pkg::NUM_PORTS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [NUM_PORTS-1:0] port_mask;
	logic                 flooded;
	logic                 learned;
	logic                 learn_dropped;

	modport source (output valid, port_mask, flooded, learned, learn_dropped,
		input ready);
	modport sink   (input valid, port_mask, flooded, learned, learn_dropped,
		output ready);
endinterface

interface mlf_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [mlf_pkg::CFG_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[design/mac_learning_forwarder.sv]
//------------------------------------------------------------------------------
// mac_learning_forwarder
// Learning bridge: learns source MAC -> port into an append-only table and
// forwards each header to the learned port or floods to the active ports.
//
//  channel | dir | handshake     | payload
//  hdr     | in  | valid/ready   | src_mac[47:0], dst_mac[47:0], in_port[3:0]
//  fwd     | out | valid/ready   | port_mask[NUM_PORTS-1:0], flooded, learned,
//          |     |               | learn_dropped
//  cfg     | in  | valid/ready   | data[3:0] = active_ports (always ready)
//
//  Each item is matched against every stored entry, none when the table
//  is empty: the single table read port scans one entry per cycle,
//  matching source and destination together.
//  One item is in work at a time; a new header is taken once the previous
//  result is in the output register, which may wait on fwd.ready.
//  Reset clears the fill count and sets active_ports to 10; table contents
//  are left as they are and never read above the fill count.
//------------------------------------------------------------------------------
`default_nettype none

module mac_learning_forwarder #(
	parameter int NUM_PORTS   = mlf_pkg::NUM_PORTS_DEF,
	parameter int TABLE_DEPTH = mlf_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mlf_hdr_if.sink   hdr,
	mlf_fwd_if.source fwd,
	mlf_cfg_if.sink   cfg
);

	mlf_pkg::mlf_cmd_t cmd;
	mlf_pkg::mlf_sts_t sts;
	logic              in_ready;

	assign hdr.ready = in_ready;

	mlf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (hdr.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mlf_datapath #(
		.NUM_PORTS   (NUM_PORTS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr),
		.fwd    (fwd),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

`default_nettype wire

[design/mlf_ctrl.sv]
//------------------------------------------------------------------------------
// mlf_ctrl
// Sequencer: accept a header, scan the table once, resolve and hand off.
//------------------------------------------------------------------------------
`default_nettype none

module mlf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output mlf_pkg::mlf_cmd_t      cmd,
	input  wire mlf_pkg::mlf_sts_t sts
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SCAN    = 2'd1;
	localparam logic [1:0] ST_DRAIN   = 2'd2;
	localparam logic [1:0] ST_RESOLVE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = sts.tbl_empty ? ST_RESOLVE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (sts.rd_last)
					state_nxt = ST_DRAIN;
			end
			// last read data is compared in this cycle
			ST_DRAIN: begin
				state_nxt = ST_RESOLVE;
			end
			ST_RESOLVE: begin
				// hold until the result register is free
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule

`default_nettype wire

[design/mlf_datapath.sv]
//------------------------------------------------------------------------------
// mlf_datapath
// Header registers, MAC table memory with registered read, match flags,
// learn/forward decision, result register and active-port register.
//------------------------------------------------------------------------------
`default_nettype none

module mlf_datapath #(
	parameter int NUM_PORTS   = mlf_pkg::NUM_PORTS_DEF,
	parameter int TABLE_DEPTH = mlf_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mlf_hdr_if.sink                hdr,
	mlf_fwd_if.source              fwd,
	mlf_cfg_if.sink                cfg,
	input  wire mlf_pkg::mlf_cmd_t cmd,
	output mlf_pkg::mlf_sts_t      sts
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int FW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = mlf_pkg::MAC_W + mlf_pkg::PORT_W;

	// table memory: {mac, port}
	logic [EW-1:0] tbl_mem [TABLE_DEPTH];
	logic [EW-1:0] rdata_q;
	logic          rd_vld_q;

	logic [FW-1:0] fill_q;
	logic [IW-1:0] rd_idx_q;

	logic [mlf_pkg::MAC_W-1:0]  src_q;
	logic [mlf_pkg::MAC_W-1:0]  dst_q;
	logic [mlf_pkg::PORT_W-1:0] inp_q;

	logic                       src_hit_q;
	logic [mlf_pkg::PORT_W-1:0] src_port_q;
	logic                       dst_hit_q;
	logic [mlf_pkg::PORT_W-1:0] dst_port_q;

	logic [mlf_pkg::CFG_W-1:0]  active_ports_q;

	logic                       out_valid_q;
	logic [NUM_PORTS-1:0]       mask_q;
	logic                       flooded_q;
	logic                       learned_q;
	logic                       dropped_q;

	logic [mlf_pkg::MAC_W-1:0]  rd_mac;
	logic [mlf_pkg::PORT_W-1:0] rd_port;
	logic                       tbl_full;
	logic                       src_bcast;
	logic                       do_learn;
	logic                       do_drop;
	logic                       src_known;
	logic [mlf_pkg::PORT_W-1:0] src_port;
	logic                       dst_hit;
	logic [mlf_pkg::PORT_W-1:0] dst_port;
	logic [NUM_PORTS-1:0]       flood_mask;
	logic [NUM_PORTS-1:0]       src_bit;
	logic [NUM_PORTS-1:0]       dst_bit;
	logic [NUM_PORTS-1:0]       mask_nxt;

	assign rd_mac  = rdata_q[EW-1:mlf_pkg::PORT_W];
	assign rd_port = rdata_q[mlf_pkg::PORT_W-1:0];

	assign tbl_full  = (fill_q == FW'(TABLE_DEPTH));
	assign src_bcast = (src_q == mlf_pkg::BCAST_MAC);
	assign do_learn  = !src_hit_q && !src_bcast && !tbl_full;
	assign do_drop   = !src_hit_q && !src_bcast && tbl_full;
	assign src_known = src_hit_q || do_learn;
	assign src_port  = src_hit_q ? src_port_q : inp_q;
	// a source learned right now is also visible to the destination lookup
	assign dst_hit   = dst_hit_q || (do_learn && (dst_q == src_q));
	assign dst_port  = dst_hit_q ? dst_port_q : inp_q;

	always_comb begin
		for (int i = 0; i < NUM_PORTS; i++) begin
			flood_mask[i] = (i < 32'(active_ports_q));
			src_bit[i]    = (32'(src_port) == i);
			dst_bit[i]    = (32'(dst_port) == i);
		end
		if (dst_hit)
			mask_nxt = dst_bit;
		else if (src_known)
			mask_nxt = flood_mask & ~src_bit;
		else
			mask_nxt = flood_mask;
	end

	assign sts.tbl_empty = (fill_q == '0);
	assign sts.rd_last   = (FW'(rd_idx_q) == fill_q - FW'(1));
	assign sts.out_free  = !out_valid_q || fwd.ready;

	assign cfg.ready = 1'b1;

	assign fwd.valid         = out_valid_q;
	assign fwd.port_mask     = mask_q;
	assign fwd.flooded       = flooded_q;
	assign fwd.learned       = learned_q;
	assign fwd.learn_dropped = dropped_q;

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && do_learn)
			tbl_mem[fill_q[IW-1:0]] <= {src_q, inp_q};
		if (cmd.rd_en)
			rdata_q <= tbl_mem[rd_idx_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q <= hdr.src_mac;
			dst_q <= hdr.dst_mac;
			inp_q <= hdr.in_port;
		end
		if (cmd.rd_en || cmd.load)
			rd_idx_q <= cmd.load ? '0 : rd_idx_q + IW'(1);
		if (rd_vld_q && !src_hit_q && rd_mac == src_q)
			src_port_q <= rd_port;
		if (rd_vld_q && !dst_hit_q && rd_mac == dst_q)
			dst_port_q <= rd_port;
		if (cmd.commit) begin
			mask_q    <= mask_nxt;
			flooded_q <= !dst_hit;
			learned_q <= do_learn;
			dropped_q <= do_drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q         <= '0;
			rd_vld_q       <= 1'b0;
			src_hit_q      <= 1'b0;
			dst_hit_q      <= 1'b0;
			out_valid_q    <= 1'b0;
			active_ports_q <= mlf_pkg::ACTIVE_PORTS_RST;
		end else begin
			rd_vld_q <= cmd.rd_en;
			if (cmd.load) begin
				src_hit_q <= 1'b0;
				dst_hit_q <= 1'b0;
			end else if (rd_vld_q) begin
				if (rd_mac == src_q)
					src_hit_q <= 1'b1;
				// broadcast never hits
				if (rd_mac == dst_q && dst_q != mlf_pkg::BCAST_MAC)
					dst_hit_q <= 1'b1;
			end
			if (cmd.commit && do_learn)
				fill_q <= fill_q + FW'(1);
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (fwd.ready)
				out_valid_q <= 1'b0;
			if (cfg.valid)
				active_ports_q <= cfg.data;
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
//------------------------------------------------------------------------------
// tb_top
// Testbench for the MAC learning forwarder. A driver offers frame headers from
// a backlog queue and a monitor checks each forwarding decision against an
// in-house bridge model, across idling modes and several active-port settings.
//------------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAC_W       = mlf_pkg::MAC_W;
	localparam int PORT_W      = mlf_pkg::PORT_W;
	localparam int CFG_W       = mlf_pkg::CFG_W;
	localparam int NPORTS      = mlf_pkg::NUM_PORTS_DEF;
	localparam int TDEPTH      = mlf_pkg::TABLE_DEPTH_DEF;
	localparam int LONG_HOLD   = 400;
	localparam int WDOG_LIMIT  = 4000;
	localparam int POOL_N      = 96;
	localparam int PHASE_N     = 8;
	localparam int PHASE_ITEMS = 216;
	localparam int REPORT_MAX  = 10;

	localparam logic [MAC_W-1:0] BCAST_MAC        = mlf_pkg::BCAST_MAC;
	localparam logic [CFG_W-1:0] ACTIVE_PORTS_RST = mlf_pkg::ACTIVE_PORTS_RST;

	localparam logic [MAC_W-1:0] MAC_A    = 48'h0200_0000_000A;
	localparam logic [MAC_W-1:0] MAC_B    = 48'h0200_0000_000B;
	localparam logic [MAC_W-1:0] MAC_C    = 48'h0200_0000_000C;
	localparam logic [MAC_W-1:0] MAC_D    = 48'h0200_0000_000D;
	localparam logic [MAC_W-1:0] MAC_E    = 48'h0200_0000_000E;
	localparam logic [MAC_W-1:0] MAC_F    = 48'h0200_0000_000F;
	localparam logic [MAC_W-1:0] MAC_G    = 48'h0200_0000_0010;
	localparam logic [MAC_W-1:0] MAC_H    = 48'h0200_0000_0011;
	localparam logic [MAC_W-1:0] MAC_ZERO = 48'h0;
	localparam logic [MAC_W-1:0] MAC_NEAR = 48'hFFFF_FFFF_FFFE;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
		logic [PORT_W-1:0] in_port;
	} frame_hdr_t;

	typedef struct packed {
		logic [NPORTS-1:0] port_mask;
		logic              flooded;
		logic              learned;
		logic              learn_dropped;
	} fwd_dec_t;

	logic clk = 1'b0;
	logic arst_n;

	mlf_hdr_if                     hdr_ch ();
	mlf_fwd_if #(.NUM_PORTS(NPORTS)) fwd_ch ();
	mlf_cfg_if                     cfg_ch ();

	mac_learning_forwarder #(
		.NUM_PORTS   (NPORTS),
		.TABLE_DEPTH (TDEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr_ch),
		.fwd    (fwd_ch),
		.cfg    (cfg_ch)
	);

	// bridge model state
	logic [MAC_W-1:0]  learn_mac  [TDEPTH];
	logic [PORT_W-1:0] learn_port [TDEPTH];
	int                learn_fill = 0;
	logic [CFG_W-1:0]  flood_ports = ACTIVE_PORTS_RST;

	frame_hdr_t hdr_backlog [$];
	fwd_dec_t   fwd_expected [$];
	logic [MAC_W-1:0] mac_pool [POOL_N];

	int   send_pct = 0;
	int   recv_pct = 0;
	int   hold_reqs = 0;
	int   mism_n = 0;
	int   quiet_n = 0;
	logic hdr_taken = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic fwd_dec_t bridge_forward(frame_hdr_t h);
		fwd_dec_t          d;
		logic              src_known;
		logic              dst_known;
		logic [PORT_W-1:0] src_port;
		logic [PORT_W-1:0] dst_port;
		logic [31:0]       flood;
		int                n;
		d = '0;
		src_known = 1'b0;
		dst_known = 1'b0;
		src_port = '0;
		dst_port = '0;
		if (h.src_mac != BCAST_MAC) begin
			for (int i = 0; i < learn_fill; i++) begin
				if (!src_known && learn_mac[i] == h.src_mac) begin
					src_known = 1'b1;
					src_port = learn_port[i];
				end
			end
			if (!src_known) begin
				if (learn_fill < TDEPTH) begin
					learn_mac[learn_fill] = h.src_mac;
					learn_port[learn_fill] = h.in_port;
					learn_fill++;
					d.learned = 1'b1;
					src_known = 1'b1;
					src_port = h.in_port;
				end else begin
					d.learn_dropped = 1'b1;
				end
			end
		end
		if (h.dst_mac != BCAST_MAC) begin
			for (int i = 0; i < learn_fill; i++) begin
				if (!dst_known && learn_mac[i] == h.dst_mac) begin
					dst_known = 1'b1;
					dst_port = learn_port[i];
				end
			end
		end
		if (dst_known) begin
			d.port_mask = (dst_port < NPORTS) ? (NPORTS'(1) << dst_port) : '0;
		end else begin
			n = (flood_ports > NPORTS) ? NPORTS : int'(flood_ports);
			flood = (32'd1 << n) - 32'd1;
			// a source learned on a port beyond the mask excludes nothing
			if (src_known && src_port < NPORTS)
				flood &= ~(32'd1 << src_port);
			d.port_mask = flood[NPORTS-1:0];
			d.flooded = 1'b1;
		end
		return d;
	endfunction

	function automatic logic [MAC_W-1:0] rand_mac();
		return MAC_W'({$urandom(), $urandom()});
	endfunction

	function automatic void queue_frame(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
			logic [PORT_W-1:0] port);
		frame_hdr_t f;
		f.src_mac = src;
		f.dst_mac = dst;
		f.in_port = port;
		hdr_backlog = {hdr_backlog, f};
	endfunction

	task automatic drain_all();
		while (hdr_backlog.size() != 0 || fwd_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_active_ports(logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// header driver: hold an offered item until taken
	always @(negedge clk) begin : hdr_driver
		frame_hdr_t nxt;
		if (!hdr_ch.valid || hdr_taken) begin
			if (hdr_backlog.size() != 0 && $urandom_range(99) >= send_pct) begin
				nxt = hdr_backlog[0];
				hdr_ch.valid <= 1'b1;
				hdr_ch.src_mac <= nxt.src_mac;
				hdr_ch.dst_mac <= nxt.dst_mac;
				hdr_ch.in_port <= nxt.in_port;
			end else begin
				hdr_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls plus requested long hold-offs
	always @(negedge clk) begin : fwd_receiver
		int hold_left;
		int hold_done;
		if (hold_done < hold_reqs) begin
			hold_left = LONG_HOLD;
			hold_done++;
		end
		if (hold_left > 0) begin
			hold_left--;
			fwd_ch.ready <= 1'b0;
		end else begin
			fwd_ch.ready <= ($urandom_range(99) >= recv_pct);
		end
	end

	always @(posedge clk) begin : monitor
		fwd_dec_t got;
		fwd_dec_t want;
		fwd_dec_t pred;
		if (cfg_ch.valid && cfg_ch.ready)
			flood_ports = cfg_ch.data;
		hdr_taken = hdr_ch.valid && hdr_ch.ready;
		if (hdr_taken) begin
			pred = bridge_forward({hdr_ch.src_mac, hdr_ch.dst_mac, hdr_ch.in_port});
			fwd_expected = {fwd_expected, pred};
			void'(hdr_backlog.pop_front());
		end
		if (fwd_ch.valid && fwd_ch.ready) begin
			got = {fwd_ch.port_mask, fwd_ch.flooded, fwd_ch.learned,
				fwd_ch.learn_dropped};
			if (fwd_expected.size() == 0) begin
				mism_n++;
				if (mism_n <= REPORT_MAX)
					$display("unexpected result: mask %h flooded %b learned %b dropped %b",
						got.port_mask, got.flooded, got.learned, got.learn_dropped);
			end else begin
				want = fwd_expected.pop_front();
				if (got.port_mask !== want.port_mask || got.flooded !== want.flooded ||
						got.learned !== want.learned ||
						got.learn_dropped !== want.learn_dropped) begin
					mism_n++;
					if (mism_n <= REPORT_MAX)
						$display({"mismatch: exp mask %h fl %b ln %b dr %b,",
							" got mask %h fl %b ln %b dr %b"},
							want.port_mask, want.flooded, want.learned,
							want.learn_dropped, got.port_mask, got.flooded,
							got.learned, got.learn_dropped);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((hdr_ch.valid && hdr_ch.ready) || (fwd_ch.valid && fwd_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_n = 0;
		else
			quiet_n++;
		if (quiet_n >= WDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0]  phase_ports [PHASE_N];
		logic [MAC_W-1:0]  src;
		logic [MAC_W-1:0]  dst;
		logic [PORT_W-1:0] port;
		int                r;
		phase_ports = '{4'd10, 4'd1, 4'd15, 4'd0, 4'd6, 4'd12, 4'd2, 4'd9};
		arst_n = 1'b0;
		hdr_ch.valid = 1'b0;
		hdr_ch.src_mac = '0;
		hdr_ch.dst_mac = '0;
		hdr_ch.in_port = '0;
		fwd_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		for (int i = 0; i < POOL_N; i++)
			mac_pool[i] = rand_mac();
		mac_pool[0] = MAC_ZERO;
		mac_pool[1] = MAC_NEAR;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: learning, moved station, broadcast, odd ports
		queue_frame(MAC_A, BCAST_MAC, 4'd3);
		queue_frame(MAC_B, MAC_A, 4'd5);
		queue_frame(MAC_A, MAC_B, 4'd7);
		queue_frame(BCAST_MAC, MAC_C, 4'd2);
		queue_frame(BCAST_MAC, BCAST_MAC, 4'd0);
		queue_frame(MAC_C, MAC_C, 4'd12);
		queue_frame(MAC_D, MAC_E, 4'd15);
		queue_frame(MAC_ZERO, MAC_ZERO, 4'd0);
		queue_frame(MAC_NEAR, MAC_B, 4'd9);
		queue_frame(MAC_E, MAC_NEAR, 4'd10);
		queue_frame(MAC_A, MAC_ZERO, 4'd4);
		queue_frame(MAC_E, MAC_F, 4'd1);
		queue_frame(MAC_B, MAC_F, 4'd6);
		drain_all();
		write_active_ports(4'd0);
		queue_frame(MAC_B, MAC_F, 4'd5);
		queue_frame(MAC_F, BCAST_MAC, 4'd8);
		drain_all();
		write_active_ports(4'd15);
		queue_frame(MAC_A, MAC_G, 4'd1);
		queue_frame(BCAST_MAC, BCAST_MAC, 4'd0);
		drain_all();
		write_active_ports(4'd1);
		queue_frame(MAC_F, BCAST_MAC, 4'd0);
		queue_frame(MAC_H, BCAST_MAC, 4'd0);
		queue_frame(MAC_A, MAC_H, 4'd2);
		drain_all();

		for (int p = 0; p < PHASE_N; p++) begin
			case (idle_mode_t'(p % 4))
				IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
				IDLE_SEND: begin send_pct = 56; recv_pct = 0;  end
				IDLE_RECV: begin send_pct = 0;  recv_pct = 56; end
				default:   begin send_pct = 29; recv_pct = 29; end
			endcase
			write_active_ports(phase_ports[p]);
			// fill the block while the receiver holds off
			if (p == 0)
				hold_reqs++;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(99);
				if (r < 78)
					src = mac_pool[$urandom_range(POOL_N-1)];
				else if (r < 84)
					src = BCAST_MAC;
				else
					src = rand_mac();
				r = $urandom_range(99);
				if (r < 65)
					dst = mac_pool[$urandom_range(POOL_N-1)];
				else if (r < 80)
					dst = BCAST_MAC;
				else
					dst = rand_mac();
				port = ($urandom_range(99) < 85) ? PORT_W'($urandom_range(NPORTS-1))
					: PORT_W'($urandom_range(15));
				queue_frame(src, dst, port);
				// pause the sender mid-phase until everything is back
				if (i == PHASE_ITEMS / 2)
					drain_all();
			end
			drain_all();
		end

		repeat (TDEPTH + 8) @(posedge clk);
		mism_n += fwd_expected.size();
		if (mism_n == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
